// ----- hdl/ffcra_pkg.sv -----
// ---------------------------------------------------------------------------
// ffcra_pkg
// Shared types and constants for the first-fit chunk run allocator.
// ---------------------------------------------------------------------------
package ffcra_pkg;

  localparam int unsigned MAX_CHUNKS = 64;
  localparam int unsigned ADDR_W     = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W      = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned CFG_W      = 7;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(64);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_ROOM  = 2'd1,
    STAT_NOT_HEAD = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] head_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] chunk_index;
    logic [LEN_W-1:0]  run_length;
  } rsp_t;

  // one chunk table entry: used flag plus run length (nonzero at run heads)
  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } chunk_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    chunk_entry_t      wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE_CHK,
    ST_RELEASE
  } state_t;

endpackage

// ----- hdl/ffcra_chunk_mem.sv -----
// ---------------------------------------------------------------------------
// ffcra_chunk_mem
// Chunk table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ffcra_chunk_mem
  import ffcra_pkg::*;
(
  input  logic         clk,
  input  mem_req_t     req,
  output chunk_entry_t rdata
);

  chunk_entry_t mem [MAX_CHUNKS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

// ----- hdl/ffcra_ctrl.sv -----
// ---------------------------------------------------------------------------
// ffcra_ctrl
// Sequencer: table clearing, first-fit scan, run marking and run release.
// ---------------------------------------------------------------------------
module ffcra_ctrl
  import ffcra_pkg::*;
#(
  parameter int unsigned CHUNK_BYTES = 100
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  req_t             req,
  input  logic [CNT_W-1:0] limit,
  output logic             busy,
  output mem_req_t         mem_req,
  input  chunk_entry_t     mem_rdata,
  output logic             done,
  output rsp_t             rsp
);

  localparam int unsigned CB_W  = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned ACC_W = CB_W + CNT_W + 1;
  localparam int unsigned CMP_W = (ACC_W > SIZE_W) ? ACC_W : SIZE_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_CHUNKS - 1);

  state_t            state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] end_idx, end_idx_next;
  logic [ADDR_W-1:0] head, head_next;
  logic [ADDR_W-1:0] chk_idx;
  logic [CNT_W-1:0]  issue, issue_next;
  logic [CNT_W-1:0]  run, run_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [SIZE_W-1:0] size, size_next;
  logic              chk_v, chk_v_next;
  logic              done_next;
  rsp_t              rsp_next;
  logic              scan_rd;
  logic [ACC_W-1:0]  acc_sum;
  logic              fit;

  // bytes covered by the current free run once this chunk joins it
  assign acc_sum = acc + ACC_W'(CHUNK_BYTES);
  assign fit     = CMP_W'(acc_sum) >= CMP_W'(size);
  assign scan_rd = issue < limit;
  assign busy    = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      idx   <= '0;
      chk_v <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      chk_v <= chk_v_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    end_idx <= end_idx_next;
    head    <= head_next;
    chk_idx <= issue[ADDR_W-1:0];
    issue   <= issue_next;
    run     <= run_next;
    len     <= len_next;
    acc     <= acc_next;
    size    <= size_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    end_idx_next  = end_idx;
    head_next     = head;
    issue_next    = issue;
    run_next      = run;
    len_next      = len;
    acc_next      = acc;
    size_next     = size;
    chk_v_next    = 1'b0;
    done_next     = 1'b0;
    rsp_next      = rsp;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx;
    mem_req.wdata = '0;
    mem_req.raddr = issue[ADDR_W-1:0];

    unique case (state)
      ST_CLEAR: begin
        mem_req.we = 1'b1;
        if (idx == LAST_ADDR) begin
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        // head entry is fetched speculatively for a free
        mem_req.raddr = req.head_index;
        if (start) begin
          head_next = req.head_index;
          size_next = req.size_bytes;
          if (req.cmd == CMD_FREE) begin
            state_next = ST_FREE_CHK;
          end else if (limit == '0) begin
            done_next = 1'b1;
            rsp_next  = '{status: STAT_NO_ROOM, chunk_index: '0, run_length: '0};
          end else begin
            state_next = ST_SCAN;
            issue_next = '0;
            run_next   = '0;
            acc_next   = '0;
          end
        end
      end

      ST_SCAN: begin
        // reads issue back to back; each entry is checked in the cycle after its read issues
        issue_next = scan_rd ? issue + CNT_W'(1) : issue;
        chk_v_next = scan_rd;
        if (chk_v) begin
          if (mem_rdata.used) begin
            run_next = '0;
            acc_next = '0;
          end else begin
            run_next = run + CNT_W'(1);
            acc_next = acc_sum;
          end
          if (!mem_rdata.used && fit) begin
            head_next    = chk_idx - run[ADDR_W-1:0];
            idx_next     = chk_idx - run[ADDR_W-1:0];
            len_next     = LEN_W'(run + CNT_W'(1));
            end_idx_next = chk_idx;
            chk_v_next   = 1'b0;
            state_next   = ST_MARK;
          end else if (CNT_W'(chk_idx) == limit - CNT_W'(1)) begin
            chk_v_next = 1'b0;
            done_next  = 1'b1;
            rsp_next   = '{status: STAT_NO_ROOM, chunk_index: '0, run_length: '0};
            state_next = ST_IDLE;
          end
        end
      end

      ST_MARK: begin
        mem_req.we         = 1'b1;
        mem_req.wdata.used = 1'b1;
        mem_req.wdata.len  = (idx == head) ? len : '0;
        if (idx == end_idx) begin
          done_next  = 1'b1;
          rsp_next   = '{status: STAT_DONE, chunk_index: head, run_length: len};
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end

      ST_FREE_CHK: begin
        if (!mem_rdata.used || mem_rdata.len == '0) begin
          done_next  = 1'b1;
          rsp_next   = '{status: STAT_NOT_HEAD, chunk_index: head, run_length: '0};
          state_next = ST_IDLE;
        end else begin
          len_next   = mem_rdata.len;
          idx_next   = head;
          run_next   = '0;
          state_next = ST_RELEASE;
        end
      end

      ST_RELEASE: begin
        mem_req.we = 1'b1;
        run_next   = run + CNT_W'(1);
        if (LEN_W'(run + CNT_W'(1)) == len || idx == LAST_ADDR) begin
          done_next  = 1'b1;
          rsp_next   = '{status: STAT_DONE, chunk_index: head, run_length: len};
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe outside idle");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> !mem_req.we)
    else $error("table write during scan");

  a_no_room_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == STAT_NO_ROOM |-> rsp.chunk_index == '0 && rsp.run_length == '0)
    else $error("no-room result carries a run");

  a_done_len: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == STAT_DONE |-> rsp.run_length != '0)
    else $error("completed request with empty run");

  a_mark_in_pool: assert property (@(posedge clk) disable iff (rst)
    state == ST_MARK |-> CNT_W'(idx) < limit && CNT_W'(end_idx) < limit)
    else $error("run marked outside active pool");

endmodule

// ----- hdl/first_fit_chunk_run_allocator_core.sv -----
// ---------------------------------------------------------------------------
// first_fit_chunk_run_allocator_core
// First-fit allocator of contiguous chunk runs over a 64-entry chunk table.
// ---------------------------------------------------------------------------
// After reset the chunk table is cleared entry by entry with busy high;
// active_chunks writes are taken during that time. A request is taken when
// start is high and busy low. An allocate scans the table one entry per cycle
// through its single read port, from chunk 0 up to the first fitting run,
// then writes one entry per cycle to mark the run; with no room it answers
// after the whole active area is read, or at once when active_chunks is
// zero. A free reads the head entry and, if it is a run head, writes one
// entry per released chunk. The result shows on rsp for one cycle with done
// high and cannot be held off; busy is low in that same cycle.
module first_fit_chunk_run_allocator_core
  import ffcra_pkg::*;
#(
  parameter int unsigned CHUNK_BYTES = 100
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output logic             done,
  output rsp_t             rsp
);

  logic [CFG_W-1:0] active_chunks;
  logic [CNT_W-1:0] limit;
  mem_req_t         mem_req;
  chunk_entry_t     mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_chunks <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_chunks <= cfg_wdata;
    end
  end

  // counts above the table size act as the full table
  assign limit = (CNT_W'(active_chunks) > CNT_W'(MAX_CHUNKS)) ?
                 CNT_W'(MAX_CHUNKS) : CNT_W'(active_chunks);

  ffcra_chunk_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ffcra_ctrl #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .limit     (limit),
    .busy      (busy),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .done      (done),
    .rsp       (rsp)
  );

endmodule
